// File: rtl/core/sgcc_pkg.sv
// shared constants, types and state encoding for the grid clash checker
package sgcc_pkg;

    localparam int GRID_DIM      = 16;
    localparam int CELL_CAPACITY = 8;
    localparam int AXIS_W        = $clog2(GRID_DIM);
    localparam int KEY_W         = 3 * AXIS_W;
    localparam int NUM_CELLS     = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int SLOT_W        = $clog2(CELL_CAPACITY);
    localparam int ADDR_W        = KEY_W + SLOT_W;
    localparam int NUM_SLOTS     = NUM_CELLS * CELL_CAPACITY;
    localparam int CNT_W         = $clog2(CELL_CAPACITY + 1);
    localparam int CLASH_MARGIN  = 30;
    localparam int RESIDUE_GAP   = 2;
    localparam int HALF_EDGE     = GRID_DIM / 2;

    localparam int POS_W  = 18;
    localparam int RAD_W  = 9;
    localparam int RES_W  = 12;
    localparam int SEL_W  = 12;
    localparam int IDX_W  = 12;
    localparam int CSZ_W  = 16;
    localparam int NBR_W  = 2;
    localparam int QUO_W  = POS_W + 1;
    localparam int CRD_W  = QUO_W + 2;
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 16;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic CFG_NEIGHBOR  = 1'b0;
    localparam logic CFG_CELL_SIZE = 1'b1;

    typedef enum logic [3:0] {
        ST_RESET_CLR,
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_REM_RD,
        ST_REM_WR,
        ST_CLEAR,
        ST_Q_CELL,
        ST_Q_CNT,
        ST_Q_ATOM,
        ST_Q_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
        logic [RES_W-1:0] residue;
        logic [RAD_W-1:0] radius;
        logic             coarse;
    } slot_t;

    typedef struct packed {
        logic                    start;
        logic signed [POS_W-1:0] dividend;
        logic [CSZ_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: rtl/core/spatial_grid_clash_check_top.sv
// top level: grid atom store with add, remove, clear and clash query
// add: three floor divisions, then a count read and write; remove: a count read and write;
// clear: one count entry zeroed per cycle; query: three floor divisions, then a scan of the cells
// (off-grid cells skipped, count read per on-grid cell, each stored atom compared), then a drain
// one item at a time; s_tready comes back with m_tvalid, later if the last result still waits
// reset: synchronous, then a sweep zeroes all 4096 count entries before s_tready rises
module spatial_grid_clash_check_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // opcode, pos_x, pos_y, pos_z, atom_radius, coarse_grain, residue, cell_select
    input  logic [sgcc_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // clash_free, cell_index, error
    output logic [sgcc_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_index,
    input  logic [sgcc_pkg::CSZ_W-1:0]    cfg_wr_data
);
    localparam int PW = sgcc_pkg::POS_W;
    localparam int CW = sgcc_pkg::CRD_W;

    sgcc_pkg::state_t state_reg, state_next;

    logic [sgcc_pkg::NBR_W-1:0] nbr_reg;
    logic [sgcc_pkg::CSZ_W-1:0] csize_reg;

    // probe / item registers
    logic [1:0]                 op_reg;
    logic signed [PW-1:0]       px_reg, py_reg, pz_reg;
    logic [sgcc_pkg::RAD_W-1:0] rad_reg;
    logic                       cg_reg;
    logic [sgcc_pkg::RES_W-1:0] res_reg;
    logic [sgcc_pkg::SEL_W-1:0] sel_reg;

    logic [1:0]           ax_reg, ax_next;
    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [CW-1:0] i_reg, j_reg, k_reg, i_next, j_next, k_next;
    logic [sgcc_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [sgcc_pkg::CNT_W-1:0]  n_reg, n_next;
    logic [sgcc_pkg::SLOT_W-1:0] a_reg, a_next;
    logic [sgcc_pkg::KEY_W-1:0]  clr_reg, clr_next;

    logic res_free_reg, res_free_next;
    logic [sgcc_pkg::IDX_W-1:0] res_idx_reg, res_idx_next;
    logic res_err_reg, res_err_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [sgcc_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // memories
    logic [sgcc_pkg::CNT_W-1:0] cnt_mem [sgcc_pkg::NUM_CELLS];
    sgcc_pkg::slot_t            slot_mem [sgcc_pkg::NUM_SLOTS];
    logic [sgcc_pkg::KEY_W-1:0]  cnt_raddr, cnt_waddr;
    logic [sgcc_pkg::CNT_W-1:0]  cnt_wdata, cnt_rd_reg;
    logic                        cnt_we;
    logic [sgcc_pkg::ADDR_W-1:0] slot_raddr, slot_waddr;
    sgcc_pkg::slot_t             slot_wdata, slot_rd_reg;
    logic                        slot_we;

    sgcc_pkg::div_req_t div_req;
    sgcc_pkg::div_rsp_t div_rsp;

    logic s_xfer, out_free, issue;
    logic signed [CW-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, reach;
    logic on_grid, scan_last, add_on_grid;
    logic [sgcc_pkg::KEY_W-1:0] cur_key, add_key;
    logic signed [CW-1:0] cell_new;

    // compare pipeline
    logic v1_reg, v2_reg, v3_reg;
    logic signed [PW:0] dx_reg, dy_reg, dz_reg;
    logic [9:0]  lim_reg;
    logic        ok_reg, scale_reg;
    logic [37:0] sx_reg, sy_reg, sz_reg;
    logic [19:0] limsq_reg;
    logic        ok3_reg, scale3_reg;
    logic        clash_reg, clash_next;
    logic signed [PW:0] dx_c, dy_c, dz_c;
    logic signed [sgcc_pkg::RES_W:0] dr_c;
    logic signed [10:0] lim_c;
    logic [39:0] d2_c;
    logic [41:0] d2s_c;

    sgcc_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    function automatic logic axis_ok(input logic signed [CW-1:0] c);
        return (c >= 0) && (c < CW'(sgcc_pkg::GRID_DIM));
    endfunction

    assign s_xfer   = s_tvalid && s_tready;
    assign s_tready = (state_reg == sgcc_pkg::ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign reach = CW'(nbr_reg);
    assign lo_x = cx_reg - reach;
    assign lo_y = cy_reg - reach;
    assign lo_z = cz_reg - reach;
    assign hi_x = cx_reg + reach;
    assign hi_y = cy_reg + reach;
    assign hi_z = cz_reg + reach;
    assign on_grid   = axis_ok(i_reg) && axis_ok(j_reg) && axis_ok(k_reg);
    assign scan_last = (k_reg == hi_z) && (j_reg == hi_y) && (i_reg == hi_x);
    assign cur_key   = {k_reg[sgcc_pkg::AXIS_W-1:0], j_reg[sgcc_pkg::AXIS_W-1:0],
                        i_reg[sgcc_pkg::AXIS_W-1:0]};
    assign add_key   = {cz_reg[sgcc_pkg::AXIS_W-1:0], cy_reg[sgcc_pkg::AXIS_W-1:0],
                        cx_reg[sgcc_pkg::AXIS_W-1:0]};
    assign add_on_grid = axis_ok(cx_reg) && axis_ok(cy_reg) && axis_ok(cz_reg);
    assign cell_new  = CW'(div_rsp.quotient) + CW'(sgcc_pkg::HALF_EDGE);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sgcc_pkg::ST_RESET_CLR:
                if (clr_reg == '1) state_next = sgcc_pkg::ST_IDLE;
            sgcc_pkg::ST_IDLE:
                if (s_xfer) begin
                    unique case (s_tdata[1:0])
                        sgcc_pkg::OP_REMOVE: state_next = sgcc_pkg::ST_REM_RD;
                        sgcc_pkg::OP_CLEAR:  state_next = sgcc_pkg::ST_CLEAR;
                        default:             state_next = sgcc_pkg::ST_DIV_GO;
                    endcase
                end
            sgcc_pkg::ST_DIV_GO:   state_next = sgcc_pkg::ST_DIV_WAIT;
            sgcc_pkg::ST_DIV_WAIT:
                if (div_rsp.done) begin
                    if (ax_reg != 2'd2)                     state_next = sgcc_pkg::ST_DIV_GO;
                    else if (op_reg == sgcc_pkg::OP_ADD)    state_next = sgcc_pkg::ST_ADD_RD;
                    else                                    state_next = sgcc_pkg::ST_Q_CELL;
                end
            sgcc_pkg::ST_ADD_RD:   state_next = sgcc_pkg::ST_ADD_WR;
            sgcc_pkg::ST_ADD_WR:   state_next = sgcc_pkg::ST_DONE;
            sgcc_pkg::ST_REM_RD:   state_next = sgcc_pkg::ST_REM_WR;
            sgcc_pkg::ST_REM_WR:   state_next = sgcc_pkg::ST_DONE;
            sgcc_pkg::ST_CLEAR:
                if (clr_reg == '1) state_next = sgcc_pkg::ST_DONE;
            sgcc_pkg::ST_Q_CELL:
                if (on_grid)        state_next = sgcc_pkg::ST_Q_CNT;
                else if (scan_last) state_next = sgcc_pkg::ST_Q_DRAIN;
            sgcc_pkg::ST_Q_CNT:
                if (cnt_rd_reg != '0) state_next = sgcc_pkg::ST_Q_ATOM;
                else if (scan_last)   state_next = sgcc_pkg::ST_Q_DRAIN;
                else                  state_next = sgcc_pkg::ST_Q_CELL;
            sgcc_pkg::ST_Q_ATOM:
                if ({1'b0, a_reg} == n_reg - sgcc_pkg::CNT_W'(1))
                    state_next = scan_last ? sgcc_pkg::ST_Q_DRAIN : sgcc_pkg::ST_Q_CELL;
            sgcc_pkg::ST_Q_DRAIN:
                if (!v1_reg && !v2_reg && !v3_reg) state_next = sgcc_pkg::ST_DONE;
            sgcc_pkg::ST_DONE:
                if (out_free) state_next = sgcc_pkg::ST_IDLE;
            default: state_next = sgcc_pkg::ST_IDLE;
        endcase
    end

    // scan position advance: k fastest, then j, then i
    logic advance;
    always_comb begin
        advance = 1'b0;
        unique case (state_reg)
            sgcc_pkg::ST_Q_CELL: advance = !on_grid;
            sgcc_pkg::ST_Q_CNT:  advance = (cnt_rd_reg == '0);
            sgcc_pkg::ST_Q_ATOM: advance = ({1'b0, a_reg} == n_reg - sgcc_pkg::CNT_W'(1));
            default:             advance = 1'b0;
        endcase
    end

    // datapath and outputs
    always_comb begin
        ax_next = ax_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        key_next = key_reg;
        n_next = n_reg;
        a_next = a_reg;
        clr_next = clr_reg;
        res_free_next = res_free_reg;
        res_idx_next = res_idx_reg;
        res_err_next = res_err_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next = m_tdata_reg;
        div_req.start = 1'b0;
        div_req.divisor = csize_reg;
        unique case (ax_reg)
            2'd0:    div_req.dividend = px_reg;
            2'd1:    div_req.dividend = py_reg;
            default: div_req.dividend = pz_reg;
        endcase
        cnt_raddr = cur_key;
        cnt_we = 1'b0;
        cnt_waddr = clr_reg;
        cnt_wdata = '0;
        slot_raddr = {key_reg, a_reg};
        slot_we = 1'b0;
        slot_waddr = {add_key, cnt_rd_reg[sgcc_pkg::SLOT_W-1:0]};
        slot_wdata.x = px_reg;
        slot_wdata.y = py_reg;
        slot_wdata.z = pz_reg;
        slot_wdata.residue = res_reg;
        slot_wdata.radius = rad_reg;
        slot_wdata.coarse = cg_reg;
        issue = 1'b0;

        unique case (state_reg)
            sgcc_pkg::ST_RESET_CLR, sgcc_pkg::ST_CLEAR: begin
                cnt_we = 1'b1;
                clr_next = clr_reg + sgcc_pkg::KEY_W'(1);
            end
            sgcc_pkg::ST_IDLE: begin
                ax_next = 2'd0;
                clr_next = '0;
                res_free_next = 1'b1;
                res_idx_next = '0;
                res_err_next = 1'b0;
            end
            sgcc_pkg::ST_DIV_GO: div_req.start = 1'b1;
            sgcc_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    ax_next = ax_reg + 2'd1;
                    if (ax_reg == 2'd2) begin
                        i_next = lo_x;
                        j_next = lo_y;
                        k_next = cell_new - reach;
                    end
                end
            end
            sgcc_pkg::ST_ADD_RD: cnt_raddr = add_key;
            sgcc_pkg::ST_ADD_WR: begin
                if (!add_on_grid) begin
                    res_err_next = 1'b1;
                end else begin
                    res_idx_next = sgcc_pkg::IDX_W'(add_key);
                    if (cnt_rd_reg >= sgcc_pkg::CNT_W'(sgcc_pkg::CELL_CAPACITY)) begin
                        res_err_next = 1'b1;
                    end else begin
                        slot_we = 1'b1;
                        cnt_we = 1'b1;
                        cnt_waddr = add_key;
                        cnt_wdata = cnt_rd_reg + sgcc_pkg::CNT_W'(1);
                    end
                end
            end
            sgcc_pkg::ST_REM_RD: cnt_raddr = sgcc_pkg::KEY_W'(sel_reg);
            sgcc_pkg::ST_REM_WR: begin
                cnt_waddr = sgcc_pkg::KEY_W'(sel_reg);
                cnt_wdata = cnt_rd_reg - sgcc_pkg::CNT_W'(1);
                cnt_we = (cnt_rd_reg != '0);
            end
            sgcc_pkg::ST_Q_CELL: key_next = cur_key;
            sgcc_pkg::ST_Q_CNT: begin
                n_next = cnt_rd_reg;
                a_next = '0;
            end
            sgcc_pkg::ST_Q_ATOM: begin
                issue = 1'b1;
                a_next = a_reg + sgcc_pkg::SLOT_W'(1);
            end
            sgcc_pkg::ST_Q_DRAIN: res_free_next = !clash_next;
            sgcc_pkg::ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next = {2'b00, res_err_reg, res_idx_reg, res_free_reg};
                end
            end
            default: ;
        endcase

        if (advance && !scan_last) begin
            if (k_reg != hi_z) begin
                k_next = k_reg + CW'(1);
            end else begin
                k_next = lo_z;
                if (j_reg != hi_y) begin
                    j_next = j_reg + CW'(1);
                end else begin
                    j_next = lo_y;
                    i_next = i_reg + CW'(1);
                end
            end
        end
    end

    // compare pipeline: differences, squares, sum and test
    always_comb begin
        dx_c = $signed({slot_rd_reg.x[PW-1], slot_rd_reg.x}) - $signed({px_reg[PW-1], px_reg});
        dy_c = $signed({slot_rd_reg.y[PW-1], slot_rd_reg.y}) - $signed({py_reg[PW-1], py_reg});
        dz_c = $signed({slot_rd_reg.z[PW-1], slot_rd_reg.z}) - $signed({pz_reg[PW-1], pz_reg});
        dr_c = $signed({1'b0, slot_rd_reg.residue}) - $signed({1'b0, res_reg});
        lim_c = $signed({2'b00, rad_reg}) + $signed({2'b00, slot_rd_reg.radius})
              - 11'sd30;
        d2_c = 40'(sx_reg) + 40'(sy_reg) + 40'(sz_reg);
        d2s_c = scale3_reg ? {d2_c, 2'b00} : {2'b00, d2_c};
        clash_next = clash_reg;
        if (v3_reg && ok3_reg && (d2_c != '0) && (d2s_c < 42'(limsq_reg)))
            clash_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sgcc_pkg::ST_RESET_CLR;
            nbr_reg <= sgcc_pkg::NBR_W'(1);
            csize_reg <= sgcc_pkg::CSZ_W'(400);
            m_tvalid_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            clr_reg <= '0;
            ax_reg <= '0;
        end else begin
            state_reg <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            clr_reg <= clr_next;
            ax_reg <= ax_next;
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    sgcc_pkg::CFG_NEIGHBOR:  nbr_reg <= cfg_wr_data[sgcc_pkg::NBR_W-1:0];
                    sgcc_pkg::CFG_CELL_SIZE: csize_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
        if (s_xfer) begin
            op_reg  <= s_tdata[1:0];
            px_reg  <= s_tdata[19:2];
            py_reg  <= s_tdata[37:20];
            pz_reg  <= s_tdata[55:38];
            rad_reg <= s_tdata[64:56];
            cg_reg  <= s_tdata[65];
            res_reg <= s_tdata[77:66];
            sel_reg <= s_tdata[89:78];
        end
        if (state_reg == sgcc_pkg::ST_DIV_WAIT && div_rsp.done) begin
            unique case (ax_reg)
                2'd0:    cx_reg <= cell_new;
                2'd1:    cy_reg <= cell_new;
                default: cz_reg <= cell_new;
            endcase
        end
        clash_reg <= (state_reg == sgcc_pkg::ST_IDLE) ? 1'b0 : clash_next;
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
        key_reg <= key_next;
        n_reg <= n_next;
        a_reg <= a_next;
        res_free_reg <= res_free_next;
        res_idx_reg <= res_idx_next;
        res_err_reg <= res_err_next;
        m_tdata_reg <= m_tdata_next;
        // stage 1
        dx_reg <= dx_c;
        dy_reg <= dy_c;
        dz_reg <= dz_c;
        lim_reg <= lim_c[9:0];
        ok_reg <= ((dr_c > 13'sd2) || (dr_c < -13'sd2)) && !lim_c[10] && (lim_c != '0);
        scale_reg <= cg_reg || slot_rd_reg.coarse;
        // stage 2
        sx_reg <= 38'(dx_reg * dx_reg);
        sy_reg <= 38'(dy_reg * dy_reg);
        sz_reg <= 38'(dz_reg * dz_reg);
        limsq_reg <= lim_reg * lim_reg;
        ok3_reg <= ok_reg;
        scale3_reg <= scale_reg;
    end

    // count memory and slot memory, read data registered
    always_ff @(posedge aclk) begin
        if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
        cnt_rd_reg <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
        slot_rd_reg <= slot_mem[slot_raddr];
    end

endmodule

// File: rtl/core/sgcc_div.sv
// iterative floor divider, one quotient bit per cycle
module sgcc_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  sgcc_pkg::div_req_t req,
    output sgcc_pkg::div_rsp_t rsp
);
    localparam int STEP_W = $clog2(sgcc_pkg::POS_W + 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic [sgcc_pkg::POS_W-1:0]    mag_reg, mag_next;
    logic [sgcc_pkg::POS_W-1:0]    quo_reg, quo_next;
    logic [sgcc_pkg::CSZ_W-1:0]    rem_reg, rem_next;
    logic [sgcc_pkg::CSZ_W-1:0]    dvs_reg, dvs_next;
    logic                          neg_reg, neg_next;
    logic [sgcc_pkg::CSZ_W:0]      shifted;
    logic                          fits;
    logic signed [sgcc_pkg::QUO_W-1:0] qpos;

    always_comb begin
        shifted   = {rem_reg, mag_reg[sgcc_pkg::POS_W-1]};
        fits      = shifted >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        mag_next  = mag_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = req.dividend[sgcc_pkg::POS_W-1];
            mag_next  = req.dividend[sgcc_pkg::POS_W-1] ?
                        sgcc_pkg::POS_W'(-req.dividend) : sgcc_pkg::POS_W'(req.dividend);
            rem_next  = '0;
            quo_next  = '0;
            // zero size acts as one
            dvs_next  = (req.divisor == '0) ? sgcc_pkg::CSZ_W'(1) : req.divisor;
        end else if (busy_reg) begin
            mag_next = {mag_reg[sgcc_pkg::POS_W-2:0], 1'b0};
            quo_next = {quo_reg[sgcc_pkg::POS_W-2:0], fits};
            rem_next = fits ? sgcc_pkg::CSZ_W'(shifted - {1'b0, dvs_reg})
                            : shifted[sgcc_pkg::CSZ_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(sgcc_pkg::POS_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        mag_reg  <= mag_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
    end

    // floor rounding for negative dividends
    assign qpos = $signed({1'b0, quo_reg});
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (-qpos - ((rem_reg != '0) ? sgcc_pkg::QUO_W'(1)
                                                              : sgcc_pkg::QUO_W'(0)))
                                  : qpos;

endmodule
